[rtl/stl_pkg.sv]
// ----------------------------------------------------------------------------
// stl_pkg
// shared token kinds, character codes, keyword table and classify helpers
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int KEYWORD_CHARS_DEF = 8;
  localparam int OFFSET_BITS_DEF   = 24;
  localparam int COUNT_BITS_DEF    = 16;

  localparam int TOK_KIND_W  = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam int KW_COUNT    = 11;
  localparam int KW_MAX_LEN  = 8;

  typedef enum logic [TOK_KIND_W-1:0] {
    K_IDENT = 6'd0, K_ASSIGN = 6'd1, K_INT = 6'd2, K_FLOAT = 6'd3, K_STRING = 6'd4,
    K_PLUS = 6'd5, K_MINUS = 6'd6, K_DIVIDE = 6'd7, K_MULTIPLY = 6'd8,
    K_MODULO = 6'd9, K_BANG = 6'd10, K_AND = 6'd11, K_OR = 6'd12,
    K_INCREMENT = 6'd13, K_DECREMENT = 6'd14, K_LT = 6'd15, K_GT = 6'd16,
    K_NE = 6'd17, K_EQ = 6'd18, K_LT_EQ = 6'd19, K_GT_EQ = 6'd20,
    K_COMMA = 6'd21, K_SEMICOLON = 6'd22, K_COMMENT = 6'd23, K_LPAREN = 6'd24,
    K_RPAREN = 6'd25, K_LBRACE = 6'd26, K_RBRACE = 6'd27, K_LBRACKET = 6'd28,
    K_RBRACKET = 6'd29, K_VAR = 6'd30, K_IF = 6'd31, K_ELSE = 6'd32,
    K_LOOP = 6'd33, K_FUNC = 6'd34, K_RETURN = 6'd35, K_BREAK = 6'd36,
    K_CONTINUE = 6'd37, K_TRUE = 6'd38, K_FALSE = 6'd39, K_STDIN = 6'd40,
    K_ILLEGAL = 6'd41, K_ERROR = 6'd42, K_EOF = 6'd43
  } tok_kind_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2e;

  // keyword text right-aligned, first char in the highest used byte
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    "break", "continue", "else", "false", "func", "if",
    "loop", "return", "stdin", "true", "var"
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd5, 4'd8, 4'd4, 4'd5, 4'd4, 4'd2, 4'd4, 4'd6, 4'd5, 4'd4, 4'd3
  };
  localparam tok_kind_t KW_KIND [KW_COUNT] = '{
    K_BREAK, K_CONTINUE, K_ELSE, K_FALSE, K_FUNC, K_IF,
    K_LOOP, K_RETURN, K_STDIN, K_TRUE, K_VAR
  };

  typedef struct packed {
    logic       is_op;
    logic [7:0] partner;
    tok_kind_t  dbl;
    tok_kind_t  sgl;
  } oper_info_t;

  typedef struct packed {
    logic push0;
    logic push1;
  } q_push_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_numeral(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic oper_info_t oper_info(input logic [7:0] c);
    oper_info_t r;
    r = '{is_op: 1'b1, partner: "=", dbl: K_ILLEGAL, sgl: K_ILLEGAL};
    unique case (c)
      "=":     begin r.dbl = K_EQ;        r.sgl = K_ASSIGN; end
      "+":     begin r.partner = "+"; r.dbl = K_INCREMENT; r.sgl = K_PLUS; end
      "-":     begin r.partner = "-"; r.dbl = K_DECREMENT; r.sgl = K_MINUS; end
      "!":     begin r.dbl = K_NE;        r.sgl = K_BANG; end
      "&":     begin r.partner = "&"; r.dbl = K_AND; end
      "|":     begin r.partner = "|"; r.dbl = K_OR; end
      "<":     begin r.dbl = K_LT_EQ;     r.sgl = K_LT; end
      ">":     begin r.dbl = K_GT_EQ;     r.sgl = K_GT; end
      default: r.is_op = 1'b0;
    endcase
    return r;
  endfunction

  function automatic tok_kind_t single_kind(input logic [7:0] c);
    tok_kind_t k;
    unique case (c)
      "/":     k = K_DIVIDE;
      "*":     k = K_MULTIPLY;
      "%":     k = K_MODULO;
      ",":     k = K_COMMA;
      ";":     k = K_SEMICOLON;
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      "{":     k = K_LBRACE;
      "}":     k = K_RBRACE;
      "[":     k = K_LBRACKET;
      "]":     k = K_RBRACKET;
      default: k = K_ILLEGAL;
    endcase
    return k;
  endfunction

  // txt holds the first eight identifier bytes, first byte in the top byte
  function automatic tok_kind_t kw_lookup(input logic [63:0] txt, input logic [3:0] len);
    tok_kind_t k;
    logic [63:0] mask;
    logic [63:0] key;
    k = K_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      mask = {64{1'b1}} << (8 * (KW_MAX_LEN - int'(KW_LEN[i])));
      key  = KW_TEXT[i] << (8 * (KW_MAX_LEN - int'(KW_LEN[i])));
      if (len == KW_LEN[i] && (txt & mask) == key) k = KW_KIND[i];
    end
    return k;
  endfunction

endpackage

[rtl/script_token_lexer_core.sv]
// ----------------------------------------------------------------------------
// script_token_lexer_core
// streaming lexer: script bytes in, token words out
// ----------------------------------------------------------------------------
// One script byte is taken per clock while in_tready is high. The scanner
// finishes its work on a byte in the cycle it is accepted and writes the
// zero, one or two token words that byte completes into a four-word queue;
// the output register takes one word per cycle from that queue unless the
// output stalls. A word passes through the queue and then the output
// register before it shows on the output. in_tready drops only while the
// queue lacks room for two words, so the byte rate is one per cycle as long
// as the bytes average at most one token word each; the single output
// register is what bounds the rate at one word per cycle. A zero byte
// flushes the open token, emits an eof word and returns the scanner to its
// reset state. There is no clearing pass after reset.
module script_token_lexer_core import stl_pkg::*; #(
  parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF,
  parameter int OFFSET_BITS   = OFFSET_BITS_DEF,
  parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // ch
  output logic out_tvalid,
  input  logic out_tready,
  // token_kind, start_offset, token_length, line_number, column, zero fill
  output logic [((TOK_KIND_W + OFFSET_BITS + 3 * COUNT_BITS + 7) / 8) * 8 - 1:0] out_tdata,
  output logic out_tlast
);

  localparam int TOK_W  = TOK_KIND_W + OFFSET_BITS + 3 * COUNT_BITS + 1;
  localparam int DATA_W = ((TOK_W - 1 + 7) / 8) * 8;

  logic             acc;
  q_push_t          push;
  logic [TOK_W-1:0] tok0, tok1;
  logic             q_room, q_valid, q_pop;
  logic [TOK_W-1:0] q_data;

  assign in_tready = q_room;
  assign acc       = in_tvalid && q_room;

  stl_scan #(
    .KEYWORD_CHARS (KEYWORD_CHARS),
    .OFFSET_BITS   (OFFSET_BITS),
    .COUNT_BITS    (COUNT_BITS),
    .TOK_W         (TOK_W)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .ch    (in_tdata),
    .push  (push),
    .tok0  (tok0),
    .tok1  (tok1)
  );

  stl_queue #(
    .TOK_W (TOK_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr0      (tok0),
    .wr1      (tok1),
    .room     (q_room),
    .rd_valid (q_valid),
    .rd_data  (q_data),
    .pop      (q_pop)
  );

  stl_outreg #(
    .TOK_W  (TOK_W),
    .DATA_W (DATA_W)
  ) u_outreg (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[rtl/stl_scan.sv]
// ----------------------------------------------------------------------------
// stl_scan
// front end: takes one byte a cycle when acc is high, runs the scanner and emits up to two tokens
// ----------------------------------------------------------------------------
module stl_scan import stl_pkg::*; #(
  parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF,
  parameter int OFFSET_BITS   = OFFSET_BITS_DEF,
  parameter int COUNT_BITS    = COUNT_BITS_DEF,
  parameter int TOK_W         = TOK_KIND_W + OFFSET_BITS + 3 * COUNT_BITS + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic [7:0]       ch,
  output q_push_t          push,
  output logic [TOK_W-1:0] tok0,
  output logic [TOK_W-1:0] tok1
);

  localparam int KW_AW = $clog2(KEYWORD_CHARS);

  typedef enum logic [2:0] {
    M_IDLE, M_COMMENT, M_IDENT, M_NUMBER, M_STRING, M_OPER
  } mode_t;

  mode_t                  mode_r, mode_nxt;
  logic [7:0]             pend_r, pend_nxt;
  logic                   flt_r, flt_nxt;
  logic [OFFSET_BITS-1:0] begin_r, begin_nxt;
  logic [COUNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic [COUNT_BITS-1:0]  line_r, line_nxt;
  logic [COUNT_BITS-1:0]  col_r, col_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [7:0]             kw_r [KEYWORD_CHARS];

  logic                   kw_we;
  logic [KW_AW-1:0]       kw_wa;
  logic [63:0]            kw_txt;
  logic [3:0]             kw_len;
  tok_kind_t              id_kind;
  oper_info_t             op_pend;
  oper_info_t             op_in;

  logic [OFFSET_BITS-1:0] pos_c;
  logic [COUNT_BITS-1:0]  col_c, cnt_c;
  logic                   idle_go;

  logic                   a_v, b_v;
  tok_kind_t              a_kind, b_kind;
  logic [OFFSET_BITS-1:0] a_start, b_start;
  logic [COUNT_BITS-1:0]  a_len, b_len, a_line, b_line, a_col, b_col;
  logic [TOK_W-1:0]       tok_a, tok_b;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
  endfunction

  always_comb begin
    for (int i = 0; i < KW_MAX_LEN; i++) kw_txt[63 - 8 * i -: 8] = kw_r[i];
  end

  assign kw_len  = (cnt_r <= COUNT_BITS'(KW_MAX_LEN)) ? cnt_r[3:0] : 4'd0;
  assign id_kind = kw_lookup(kw_txt, kw_len);
  assign op_pend = oper_info(pend_r);
  assign op_in   = oper_info(ch);

  assign pos_c = pos_r + 1'b1;
  assign col_c = sat_inc(col_r);
  assign cnt_c = sat_inc(cnt_r);

  always_comb begin
    mode_nxt  = mode_r;
    pend_nxt  = pend_r;
    flt_nxt   = flt_r;
    begin_nxt = begin_r;
    cnt_nxt   = cnt_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    pos_nxt   = pos_r;
    kw_we     = 1'b0;
    kw_wa     = cnt_r[KW_AW-1:0];
    idle_go   = 1'b0;
    a_v = 1'b0; a_kind = K_IDENT; a_start = begin_r; a_len = cnt_r;
    a_line = line_r; a_col = col_r;
    b_v = 1'b0; b_kind = K_EOF; b_start = pos_r; b_len = '0;
    b_line = line_r; b_col = col_r;

    unique case (mode_r)
      M_COMMENT: begin
        if (ch != CH_LF && ch != CH_NUL) begin
          pos_nxt = pos_c; col_nxt = col_c; cnt_nxt = cnt_c;
        end else begin
          mode_nxt = M_IDLE; idle_go = 1'b1;
        end
      end
      M_IDENT: begin
        if (is_letter(ch) || is_numeral(ch)) begin
          kw_we   = (cnt_r < COUNT_BITS'(KEYWORD_CHARS));
          pos_nxt = pos_c; col_nxt = col_c; cnt_nxt = cnt_c;
        end else begin
          a_v = 1'b1; a_kind = id_kind;
          mode_nxt = M_IDLE; idle_go = 1'b1;
        end
      end
      M_NUMBER: begin
        if (is_numeral(ch) || ch == CH_DOT) begin
          if (ch == CH_DOT) flt_nxt = 1'b1;
          pos_nxt = pos_c; col_nxt = col_c; cnt_nxt = cnt_c;
        end else begin
          a_v = 1'b1; a_kind = flt_r ? K_FLOAT : K_INT;
          mode_nxt = M_IDLE; idle_go = 1'b1;
        end
      end
      M_STRING: begin
        if (ch == CH_NUL) begin
          a_v = 1'b1; a_kind = K_ERROR;
          mode_nxt = M_IDLE; idle_go = 1'b1;
        end else begin
          // a newline inside a string bumps the line but keeps the column
          if (ch == CH_LF) line_nxt = sat_inc(line_r);
          pos_nxt = pos_c; col_nxt = col_c; cnt_nxt = cnt_c;
          if (ch == CH_QUOTE) begin
            mode_nxt = M_IDLE;
            a_v = 1'b1; a_kind = K_STRING; a_len = cnt_c; a_col = col_c;
            a_line = line_r;
          end
        end
      end
      M_OPER: begin
        if (ch != CH_NUL && op_pend.is_op && ch == op_pend.partner) begin
          pos_nxt = pos_c; col_nxt = col_c; cnt_nxt = cnt_c;
          mode_nxt = M_IDLE;
          a_v = 1'b1; a_kind = op_pend.dbl; a_len = cnt_c; a_col = col_c;
        end else begin
          a_v = 1'b1; a_kind = op_pend.sgl;
          mode_nxt = M_IDLE; idle_go = 1'b1;
        end
      end
      M_IDLE: idle_go = 1'b1;
      default: idle_go = 1'b1;
    endcase

    if (idle_go) begin
      if (ch == CH_NUL) begin
        // end of script: eof word, then back to the reset state
        b_v = 1'b1;
        mode_nxt = M_IDLE; pend_nxt = '0; flt_nxt = 1'b0; begin_nxt = '0;
        cnt_nxt = '0; line_nxt = COUNT_BITS'(1); col_nxt = '0; pos_nxt = '0;
      end else if (ch == CH_SPACE || ch == CH_TAB || ch == CH_CR) begin
        pos_nxt = pos_c; col_nxt = col_c; cnt_nxt = cnt_c;
      end else if (ch == CH_LF) begin
        pos_nxt = pos_c; cnt_nxt = cnt_c;
        line_nxt = sat_inc(line_r); col_nxt = '0;
      end else if (ch == CH_HASH) begin
        pos_nxt = pos_c; col_nxt = col_c; cnt_nxt = cnt_c;
        mode_nxt = M_COMMENT;
      end else begin
        begin_nxt = pos_r;
        cnt_nxt   = COUNT_BITS'(1);
        pos_nxt   = pos_c;
        col_nxt   = col_c;
        if (is_letter(ch)) begin
          kw_we = 1'b1; kw_wa = '0;
          mode_nxt = M_IDENT;
        end else if (is_numeral(ch)) begin
          flt_nxt = 1'b0; mode_nxt = M_NUMBER;
        end else if (ch == CH_QUOTE) begin
          mode_nxt = M_STRING;
        end else if (op_in.is_op) begin
          pend_nxt = ch; mode_nxt = M_OPER;
        end else begin
          b_v = 1'b1; b_kind = single_kind(ch); b_start = pos_r;
          b_len = COUNT_BITS'(1); b_col = col_c;
        end
      end
    end
  end

  assign tok_a = {~b_v, a_col, a_line, a_len, a_start, a_kind};
  assign tok_b = {1'b1, b_col, b_line, b_len, b_start, b_kind};

  assign tok0       = a_v ? tok_a : tok_b;
  assign tok1       = tok_b;
  assign push.push0 = acc && (a_v || b_v);
  assign push.push1 = acc && a_v && b_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      pend_r  <= '0;
      flt_r   <= 1'b0;
      begin_r <= '0;
      cnt_r   <= '0;
      line_r  <= COUNT_BITS'(1);
      col_r   <= '0;
      pos_r   <= '0;
    end else if (acc) begin
      mode_r  <= mode_nxt;
      pend_r  <= pend_nxt;
      flt_r   <= flt_nxt;
      begin_r <= begin_nxt;
      cnt_r   <= cnt_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && kw_we) kw_r[kw_wa] <= ch;
  end

endmodule

[rtl/stl_queue.sv]
// ----------------------------------------------------------------------------
// stl_queue
// small token queue: up to two words in per cycle, one word out
// ----------------------------------------------------------------------------
module stl_queue import stl_pkg::*; #(
  parameter int TOK_W = TOK_KIND_W + OFFSET_BITS_DEF + 3 * COUNT_BITS_DEF + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  q_push_t          push,
  input  logic [TOK_W-1:0] wr0,
  input  logic [TOK_W-1:0] wr1,
  output logic             room,
  output logic             rd_valid,
  output logic [TOK_W-1:0] rd_data,
  input  logic             pop
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [TOK_W-1:0] mem_r [QUEUE_DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  // room for the two words a single byte may produce
  assign room     = (cnt_r <= CW'(QUEUE_DEPTH - 2));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r + PW'(push.push0) + PW'(push.push1);
    rp_nxt  = rp_r + PW'(pop);
    cnt_nxt = cnt_r + CW'(push.push0) + CW'(push.push1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push0) mem_r[wp_r] <= wr0;
    if (push.push1) mem_r[wp_r + 1'b1] <= wr1;
  end

endmodule

[rtl/stl_outreg.sv]
// ----------------------------------------------------------------------------
// stl_outreg
// back end: output register that drains the queue onto the result stream
// ----------------------------------------------------------------------------
module stl_outreg import stl_pkg::*; #(
  parameter int TOK_W  = TOK_KIND_W + OFFSET_BITS_DEF + 3 * COUNT_BITS_DEF + 1,
  parameter int DATA_W = ((TOK_W - 1 + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  logic [TOK_W-1:0]  q_data,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,
  output logic              out_tlast
);

  logic             valid_r;
  logic [TOK_W-1:0] data_r;

  assign q_pop      = q_valid && (!valid_r || out_tready);
  assign out_tvalid = valid_r;
  assign out_tdata  = DATA_W'(data_r[TOK_W-2:0]);
  assign out_tlast  = data_r[TOK_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) data_r <= q_data;
  end

endmodule

[rtl/stl_checker.sv]
// ----------------------------------------------------------------------------
// stl_checker
// port-level checks on the token stream, bound to the lexer top level
// ----------------------------------------------------------------------------
module stl_checker import stl_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [((TOK_KIND_W + OFFSET_BITS + 3 * COUNT_BITS + 7) / 8) * 8 - 1:0] out_tdata,
  input logic out_tlast
);

  localparam int LEN_LO  = TOK_KIND_W + OFFSET_BITS;
  localparam int LINE_LO = LEN_LO + COUNT_BITS;

  logic [TOK_KIND_W-1:0] kind;
  logic [COUNT_BITS-1:0] len;
  logic [COUNT_BITS-1:0] line;

  assign kind = out_tdata[TOK_KIND_W-1:0];
  assign len  = out_tdata[LEN_LO +: COUNT_BITS];
  assign line = out_tdata[LINE_LO +: COUNT_BITS];

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("token word changed while stalled");

  // empty and ready to take bytes right after reset
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid && in_tready)
    else $error("token word valid or input not ready right after reset");

  // eof closes the script and is empty
  a_eof: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && kind == K_EOF |-> out_tlast && len == '0)
    else $error("eof word not last or not empty");

  a_illegal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && kind == K_ILLEGAL |-> len == COUNT_BITS'(1))
    else $error("illegal word longer than one byte");

  a_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> line != '0)
    else $error("line number zero");

endmodule

bind script_token_lexer_core stl_checker #(
  .OFFSET_BITS (OFFSET_BITS),
  .COUNT_BITS  (COUNT_BITS)
) u_stl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

[tb/sv/stl_token_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stl_token_checker
// watches the byte and token channels of the lexer, predicts every token word
// from the accepted script bytes and compares each token word field by field
// ----------------------------------------------------------------------------
module stl_token_checker import stl_pkg::*; #(
  parameter int OFF_W  = OFFSET_BITS_DEF,
  parameter int CNT_W  = COUNT_BITS_DEF,
  parameter int KW_N   = KEYWORD_CHARS_DEF,
  parameter int WORD_W = ((TOK_KIND_W + OFF_W + 3 * CNT_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [WORD_W-1:0] out_tdata,
  input  logic              out_tlast,
  output int                fail_count,
  output int                pending_words
);

  localparam int LEN_LSB  = TOK_KIND_W + OFF_W;
  localparam int LINE_LSB = LEN_LSB + CNT_W;
  localparam int COL_LSB  = LINE_LSB + CNT_W;
  localparam int FILL_LSB = COL_LSB + CNT_W;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_COMMENT, SCAN_IDENT, SCAN_NUMBER, SCAN_STRING, SCAN_OPER
  } scan_t;

  typedef struct packed {
    tok_kind_t        kind;
    logic [OFF_W-1:0] start;
    logic [CNT_W-1:0] len;
    logic [CNT_W-1:0] line;
    logic [CNT_W-1:0] col;
    logic             last;
  } token_t;

  scan_t            mode;
  logic [7:0]       op_char;
  logic             is_float;
  logic [OFF_W-1:0] tok_start;
  logic [OFF_W-1:0] pos;
  logic [CNT_W-1:0] tok_len;
  logic [CNT_W-1:0] line_no;
  logic [CNT_W-1:0] col_no;
  logic [7:0]       id_buf [KW_N];

  token_t step_tok [2];
  int     step_n;
  token_t token_q [$];
  int     mismatches;

  function automatic logic [CNT_W-1:0] sat_up(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic alpha_c(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic digit_c(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // bytes that may start a two-byte operator, with the byte that pairs up
  function automatic logic pair_info(input logic [7:0] c, output logic [7:0] partner,
                                     output tok_kind_t dbl, output tok_kind_t sgl);
    partner = "=";
    dbl = K_ILLEGAL;
    sgl = K_ILLEGAL;
    case (c)
      "=": begin dbl = K_EQ;    sgl = K_ASSIGN; end
      "!": begin dbl = K_NE;    sgl = K_BANG; end
      "<": begin dbl = K_LT_EQ; sgl = K_LT; end
      ">": begin dbl = K_GT_EQ; sgl = K_GT; end
      "+": begin partner = "+"; dbl = K_INCREMENT; sgl = K_PLUS; end
      "-": begin partner = "-"; dbl = K_DECREMENT; sgl = K_MINUS; end
      "&": begin partner = "&"; dbl = K_AND; end
      "|": begin partner = "|"; dbl = K_OR; end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic tok_kind_t lone_kind(input logic [7:0] c);
    case (c)
      "/": return K_DIVIDE;
      "*": return K_MULTIPLY;
      "%": return K_MODULO;
      ",": return K_COMMA;
      ";": return K_SEMICOLON;
      "(": return K_LPAREN;
      ")": return K_RPAREN;
      "{": return K_LBRACE;
      "}": return K_RBRACE;
      "[": return K_LBRACKET;
      "]": return K_RBRACKET;
      default: return K_ILLEGAL;
    endcase
  endfunction

  // exact-length keyword match: identifier bytes never are zero
  function automatic tok_kind_t word_kind();
    logic [63:0] text;
    tok_kind_t   k;
    text = '0;
    k = K_IDENT;
    if (tok_len <= KW_N) begin
      for (int i = 0; i < KW_N; i++)
        if (i < tok_len) text = {text[55:0], id_buf[i]};
      case (text)
        "break":    k = K_BREAK;
        "continue": k = K_CONTINUE;
        "else":     k = K_ELSE;
        "false":    k = K_FALSE;
        "func":     k = K_FUNC;
        "if":       k = K_IF;
        "loop":     k = K_LOOP;
        "return":   k = K_RETURN;
        "stdin":    k = K_STDIN;
        "true":     k = K_TRUE;
        "var":      k = K_VAR;
        default:    k = K_IDENT;
      endcase
    end
    return k;
  endfunction

  function automatic void clear_state();
    mode = SCAN_IDLE;
    op_char = '0;
    is_float = 1'b0;
    tok_start = '0;
    tok_len = '0;
    line_no = CNT_W'(1);
    col_no = '0;
    pos = '0;
    for (int i = 0; i < KW_N; i++) id_buf[i] = '0;
  endfunction

  function automatic void advance();
    pos = pos + 1'b1;
    col_no = sat_up(col_no);
    tok_len = sat_up(tok_len);
  endfunction

  function automatic void note_token(input tok_kind_t kind, input logic [OFF_W-1:0] start,
                                     input logic [CNT_W-1:0] len);
    step_tok[step_n] = '{kind, start, len, line_no, col_no, 1'b0};
    step_n++;
  endfunction

  function automatic void lex_byte(input logic [7:0] c);
    logic       rescan;
    logic [7:0] partner;
    tok_kind_t  dbl;
    tok_kind_t  sgl;
    token_t     t;
    step_n = 0;
    rescan = 1'b1;
    case (mode)
      SCAN_COMMENT: begin
        if (c != CH_LF && c != CH_NUL) begin
          advance();
          rescan = 1'b0;
        end
      end
      SCAN_IDENT: begin
        if (alpha_c(c) || digit_c(c)) begin
          if (tok_len < KW_N) id_buf[tok_len] = c;
          advance();
          rescan = 1'b0;
        end else begin
          note_token(word_kind(), tok_start, tok_len);
        end
      end
      SCAN_NUMBER: begin
        if (digit_c(c) || c == CH_DOT) begin
          if (c == CH_DOT) is_float = 1'b1;
          advance();
          rescan = 1'b0;
        end else begin
          note_token(is_float ? K_FLOAT : K_INT, tok_start, tok_len);
        end
      end
      SCAN_STRING: begin
        if (c == CH_NUL) begin
          note_token(K_ERROR, tok_start, tok_len);
        end else begin
          // newline inside a string bumps the line but keeps the column running
          rescan = 1'b0;
          if (c == CH_LF) line_no = sat_up(line_no);
          advance();
          if (c == CH_QUOTE) begin
            mode = SCAN_IDLE;
            note_token(K_STRING, tok_start, tok_len);
          end
        end
      end
      SCAN_OPER: begin
        void'(pair_info(op_char, partner, dbl, sgl));
        if (c != CH_NUL && c == partner) begin
          advance();
          mode = SCAN_IDLE;
          note_token(dbl, tok_start, tok_len);
          rescan = 1'b0;
        end else begin
          note_token(sgl, tok_start, tok_len);
        end
      end
      default: ;
    endcase

    if (rescan) begin
      mode = SCAN_IDLE;
      if (c == CH_NUL) begin
        note_token(K_EOF, pos, '0);
        clear_state();
      end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
        advance();
      end else if (c == CH_LF) begin
        advance();
        line_no = sat_up(line_no);
        col_no = '0;
      end else if (c == CH_HASH) begin
        advance();
        mode = SCAN_COMMENT;
      end else begin
        tok_start = pos;
        tok_len = '0;
        advance();
        if (alpha_c(c)) begin
          id_buf[0] = c;
          mode = SCAN_IDENT;
        end else if (digit_c(c)) begin
          is_float = 1'b0;
          mode = SCAN_NUMBER;
        end else if (c == CH_QUOTE) begin
          mode = SCAN_STRING;
        end else if (pair_info(c, partner, dbl, sgl)) begin
          op_char = c;
          mode = SCAN_OPER;
        end else begin
          note_token(lone_kind(c), tok_start, tok_len);
        end
      end
    end

    for (int i = 0; i < step_n; i++) begin
      t = step_tok[i];
      t.last = (i == step_n - 1);
      token_q.push_back(t);
    end
  endfunction

  function automatic void diff_field(input string fname, input logic [31:0] want,
                                     input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: token word %s mismatch, expected %0d actual %0d",
               $time, fname, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_word();
    token_t want;
    if (token_q.size() == 0) begin
      $display("%0t: token word with none expected, expected none actual %h",
               $time, out_tdata);
      mismatches++;
    end else begin
      want = token_q.pop_front();
      diff_field("kind", 32'(want.kind), 32'(out_tdata[TOK_KIND_W-1:0]));
      diff_field("start", 32'(want.start), 32'(out_tdata[TOK_KIND_W +: OFF_W]));
      diff_field("length", 32'(want.len), 32'(out_tdata[LEN_LSB +: CNT_W]));
      diff_field("line", 32'(want.line), 32'(out_tdata[LINE_LSB +: CNT_W]));
      diff_field("column", 32'(want.col), 32'(out_tdata[COL_LSB +: CNT_W]));
      diff_field("fill", 32'd0, 32'(out_tdata[WORD_W-1:FILL_LSB]));
      diff_field("tlast", 32'(want.last), 32'(out_tlast));
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      token_q.delete();
      clear_state();
    end else begin
      if (in_tvalid && in_tready) lex_byte(in_tdata);
      if (out_tvalid && out_tready) check_word();
    end
    fail_count <= mismatches;
    pending_words <= token_q.size();
  end

endmodule

[tb/sv/tb_script_token_lexer_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_script_token_lexer_core
// feeds directed and random scripts into the lexer with random gaps and
// output stalls; the checker predicts and compares the token words
// ----------------------------------------------------------------------------
module tb_script_token_lexer_core;
  import stl_pkg::*;

  localparam int WORD_W      = ((TOK_KIND_W + OFFSET_BITS_DEF + 3 * COUNT_BITS_DEF + 7) / 8) * 8;
  localparam int SCRIPT_BYTES = 700;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [7:0]        in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [WORD_W-1:0] out_tdata;
  logic              out_tlast;

  int         fail_count;
  int         pending_words;
  int         cycle_no = 0;
  int         sent_count = 0;
  logic       send_burst = 1'b0;
  logic [7:0] script_q [$];

  script_token_lexer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  stl_token_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_no <= cycle_no + 1;

  initial begin
    wait (cycle_no >= CYCLE_LIMIT);
    $display("[script_token_lexer_core] ERROR");
    $finish;
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic string kw_word(input int i);
    case (i)
      0: return "break";
      1: return "continue";
      2: return "else";
      3: return "false";
      4: return "func";
      5: return "if";
      6: return "loop";
      7: return "return";
      8: return "stdin";
      9: return "true";
      default: return "var";
    endcase
  endfunction

  function automatic string oper_word(input int i);
    case (i)
      0: return "=";
      1: return "==";
      2: return "+";
      3: return "++";
      4: return "-";
      5: return "--";
      6: return "!";
      7: return "!=";
      8: return "&&";
      9: return "||";
      10: return "<";
      11: return "<=";
      12: return ">";
      13: return ">=";
      14: return "/";
      15: return "*";
      16: return "%";
      17: return ",";
      18: return ";";
      19: return "(";
      20: return ")";
      21: return "{";
      22: return "}";
      23: return "[";
      24: return "]";
      25: return "&";
      default: return "|";
    endcase
  endfunction

  function automatic logic [7:0] pick_char(input string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) script_q.push_back(s[i]);
  endfunction

  function automatic void add_ident();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 6);
    script_q.push_back(pick_char("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_"));
    for (int i = 1; i < n; i++)
      script_q.push_back(pick_char("abefikloprstuvzAEIZ_0123456789"));
  endfunction

  function automatic void add_number();
    int n;
    n = $urandom_range(1, 6);
    script_q.push_back(pick_char("0123456789"));
    for (int i = 1; i < n; i++)
      script_q.push_back(($urandom_range(0, 5) == 0) ? CH_DOT : pick_char("0123456789"));
  endfunction

  // string body: any nonzero byte but the quote, newlines now and then
  function automatic void add_string_body();
    logic [7:0] b;
    int         n;
    n = $urandom_range(0, 8);
    script_q.push_back(CH_QUOTE);
    for (int i = 0; i < n; i++) begin
      b = ($urandom_range(0, 5) == 0) ? CH_LF : 8'($urandom_range(1, 255));
      if (b == CH_QUOTE) b = "q";
      script_q.push_back(b);
    end
  endfunction

  function automatic void add_comment_body();
    logic [7:0] b;
    int         n;
    n = $urandom_range(0, 6);
    script_q.push_back(CH_HASH);
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(1, 255));
      if (b == CH_LF) b = "c";
      script_q.push_back(b);
    end
  endfunction

  function automatic void add_token();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      push_text(kw_word($urandom_range(0, 10)));
      // keyword prefix of a longer identifier must stay an identifier
      if ($urandom_range(0, 2) == 0) script_q.push_back(pick_char("se_9"));
    end else if (r < 30) begin
      add_ident();
    end else if (r < 42) begin
      add_number();
    end else if (r < 52) begin
      add_string_body();
      script_q.push_back(CH_QUOTE);
    end else if (r < 80) begin
      push_text(oper_word($urandom_range(0, 26)));
    end else if (r < 88) begin
      add_comment_body();
      script_q.push_back(CH_LF);
    end else begin
      script_q.push_back(8'($urandom_range(1, 255)));
    end
  endfunction

  function automatic void build_script();
    int n_tok;
    int r;
    n_tok = $urandom_range(1, 12);
    for (int i = 0; i < n_tok; i++) begin
      add_token();
      if ($urandom_range(0, 9) < 7) begin
        r = $urandom_range(1, 2);
        for (int j = 0; j < r; j++) script_q.push_back(pick_char(" \t\r\n  \n"));
      end
    end
    r = $urandom_range(0, 9);
    case (r)
      6: begin add_string_body(); script_q.push_back(CH_NUL); end
      7: begin add_comment_body(); script_q.push_back(CH_NUL); end
      8: begin push_text(oper_word($urandom_range(0, 13))); script_q.push_back(CH_NUL); end
      9: ;
      default: script_q.push_back(CH_NUL);
    endcase
  endfunction

  // starts and ends at a falling edge
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = send_burst ? 0 : idle_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    sent_count++;
  endtask

  task automatic flush_script();
    while (script_q.size() > 0) send_byte(script_q.pop_front());
  endtask

  // token word receiver: random stalls, one long hold-off, stall-free stretches
  initial begin
    int   stall_left;
    int   r;
    logic held_once;
    logic take_burst;
    stall_left = 0;
    held_once = 1'b0;
    take_burst = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      r = $urandom_range(0, 99);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!held_once && cycle_no >= HOLD_AT) begin
        held_once = 1'b1;
        stall_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 499) == 0) begin
        stall_left = $urandom_range(40, 150);
        out_tready <= 1'b0;
      end else if (take_burst || r < 70) begin
        out_tready <= 1'b1;
      end else begin
        if (r >= 96) stall_left = $urandom_range(4, 15);
        out_tready <= 1'b0;
      end
      if ($urandom_range(0, 199) == 0) take_burst = ~take_burst;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // keyword and keyword prefix, a pair operator, lone & and |, float, high byte,
    // end inside a string with a newline, end inside a comment, end after
    // an operator byte
    push_text("if iff<=9.1&|");
    script_q.push_back(8'hff);
    push_text("\"a\n");
    script_q.push_back(CH_NUL);
    push_text("#c");
    script_q.push_back(CH_NUL);
    push_text("+");
    script_q.push_back(CH_NUL);
    flush_script();

    while (sent_count < SCRIPT_BYTES) begin
      send_burst = ($urandom_range(0, 3) == 0);
      build_script();
      flush_script();
    end
    in_tvalid <= 1'b0;

    while (pending_words != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("[script_token_lexer_core] OK");
    else
      $display("[script_token_lexer_core] ERROR");
    $finish;
  end

endmodule

[script_token_lexer_core.f]
rtl/stl_pkg.sv
rtl/stl_scan.sv
rtl/stl_queue.sv
rtl/stl_outreg.sv
rtl/script_token_lexer_core.sv
rtl/stl_checker.sv
tb/sv/stl_token_checker.sv
tb/sv/tb_script_token_lexer_core.sv
